FILE: design/time_slice_rotation_scheduler_assert.svh
// Assertion macros shared by the scheduler modules.
`ifndef TIME_SLICE_ROTATION_SCHEDULER_ASSERT_SVH
`define TIME_SLICE_ROTATION_SCHEDULER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TSRS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TSRS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TSRS_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define TSRS_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif

`endif

FILE: design/tsrs_pkg.sv
package tsrs_pkg;

   localparam int WATCHES_DEF    = 8;
   localparam int MAX_PERIOD_DEF = 4;
   localparam int MAX_HOLD_DEF   = 3;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 24;
   localparam int HOLD_W = 4;
   localparam int SLICE_US_W = 30;

   localparam logic [CSR_IW-1:0] REG_SLICE_MS     = 2'd0;
   localparam logic [CSR_IW-1:0] REG_SLOT_COUNT   = 2'd1;
   localparam logic [CSR_IW-1:0] REG_ARMED_MASK   = 2'd2;
   localparam logic [CSR_IW-1:0] REG_PERIOD_TABLE = 2'd3;

   localparam logic [19:0] SLICE_MS_MIN = 20'd2000;
   localparam logic [9:0]  US_PER_MS    = 10'd1000;
   localparam logic [SLICE_US_W-1:0] SLICE_US_RESET = 30'd2000000;
   localparam logic [23:0] PERIOD_TABLE_RESET = 24'h249249;

   typedef logic [1:0] emit_kind_type;
   localparam emit_kind_type EMIT_NONE  = 2'd0;  // no armed slot in use
   localparam emit_kind_type EMIT_KEEP  = 2'd1;  // same slot, no new grant
   localparam emit_kind_type EMIT_FIRST = 2'd2;  // first grant
   localparam emit_kind_type EMIT_MOVE  = 2'd3;  // grant after search

   typedef struct packed {
      logic          capture;
      logic          start;
      logic          calc;
      logic          hold;
      logic          search_init;
      logic          step;
      logic          reduce_load;
      logic          reduce_sub;
      logic          emit;
      emit_kind_type emit_kind;
   } tsrs_cmd_type;

   typedef struct packed {
      logic none_armed;
      logic first;
      logic over;
      logic hold_req;
      logic hold_avail;
      logic stale;
      logic mod_ge_n;
      logic due_next;
      logic steps_last;
      logic out_free;
   } tsrs_status_type;

endpackage

FILE: design/tsrs_ctrl.sv
module tsrs_ctrl import tsrs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  tsrs_status_type status,
   output tsrs_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_SLICE  = 3'd2;
   localparam logic [2:0] S_STEP   = 3'd3;
   localparam logic [2:0] S_REDUCE = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0]    state_ff, state_in;
   emit_kind_type kind_ff, kind_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.emit_kind = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.none_armed) begin
               kind_in  = EMIT_NONE;
               state_in = S_OUT;
            end else if (status.first) begin
               cmd.start = 1'b1;
               kind_in   = EMIT_FIRST;
               state_in  = S_OUT;
            end else begin
               cmd.calc = 1'b1;
               state_in = S_SLICE;
            end
         end
         S_SLICE: begin
            if (!status.over) begin
               kind_in  = EMIT_KEEP;
               state_in = S_OUT;
            end else if (status.hold_req && status.hold_avail) begin
               cmd.hold = 1'b1;
               kind_in  = EMIT_KEEP;
               state_in = S_OUT;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = S_STEP;
            end
         end
         S_STEP: begin
            if (status.stale) begin
               // cursor left behind by a shrunken ring: reduce modulo n first
               cmd.reduce_load = 1'b1;
               state_in        = S_REDUCE;
            end else begin
               cmd.step = 1'b1;
               if (status.due_next || status.steps_last) begin
                  kind_in  = EMIT_MOVE;
                  state_in = S_OUT;
               end
            end
         end
         S_REDUCE: begin
            if (status.mod_ge_n) begin
               cmd.reduce_sub = 1'b1;
            end else begin
               cmd.step = 1'b1;
               if (status.due_next || status.steps_last) begin
                  kind_in  = EMIT_MOVE;
                  state_in = S_OUT;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= EMIT_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

`include "time_slice_rotation_scheduler_assert.svh"

   `TSRS_ASSERT_NXT(a_capture_to_check, clock, reset, cmd.capture, state_ff == S_CHECK, "capture did not start check")
   `TSRS_ASSERT_NXT(a_stale_to_reduce, clock, reset, state_ff == S_STEP && status.stale, state_ff == S_REDUCE, "stale cursor not reduced")
   `TSRS_ASSERT_NXT(a_emit_to_idle, clock, reset, cmd.emit, state_ff == S_IDLE && !req_stall, "no return to idle after result")

endmodule

FILE: design/tsrs_dp.sv
module tsrs_dp import tsrs_pkg::*; #(
   parameter int WATCHES    = WATCHES_DEF,
   parameter int MAX_PERIOD = MAX_PERIOD_DEF,
   parameter int MAX_HOLD   = MAX_HOLD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  logic [63:0]       req_now_us,
   input  logic              req_hold_request,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_active_valid,
   output logic [2:0]        rsp_active_slot,
   output logic              rsp_turn_changed,
   output logic [31:0]       rsp_visit_count,
   input  tsrs_cmd_type      cmd,
   output tsrs_status_type   status
);

   localparam int CW = $clog2(WATCHES);
   localparam int NW = $clog2(WATCHES + 1);
   localparam int SW = $clog2(2 * WATCHES + 1);
   localparam int XW = WATCHES + 8;

   // configuration
   logic [SLICE_US_W-1:0] slice_us_ff, slice_us_in;
   logic [3:0]            slot_count_ff;
   logic [7:0]            armed_mask_ff;
   logic [23:0]           period_table_ff;
   logic [19:0]           slice_ms_sat;

   // scheduler state
   logic [63:0]       ho_ff;
   logic [CW-1:0]     cursor_ff;
   logic [HOLD_W-1:0] hold_cnt_ff;
   logic [31:0]       lap_ff;
   logic [2:0]        res_ff [MAX_PERIOD];
   logic [31:0]       vc_ff [WATCHES];

   // per-item work registers
   logic [63:0]   now_ff;
   logic          hold_req_ff;
   logic [63:0]   elapsed_ff;
   logic          ge_ff;
   logic [CW-1:0] was_ff;
   logic [SW-1:0] steps_ff;
   logic [NW-1:0] mod_ff;
   logic          src_mod_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_active_valid_ff;
   logic [2:0]  rsp_active_slot_ff;
   logic        rsp_turn_changed_ff;
   logic [31:0] rsp_visit_count_ff;

   logic [NW-1:0]   n;
   logic [XW-1:0]   mask_ext;
   logic [3*XW-1:0] period_ext;
   logic [WATCHES-1:0] armed_vec, use_armed;
   logic [2:0]      per_p [WATCHES];
   logic [CW-1:0]   first_idx;
   logic [NW-1:0]   cur_inc;
   logic            wrap;
   logic [CW-1:0]   step_next;
   logic            lap_inc;
   logic            lap_wrap;
   logic [2:0]      res_next [MAX_PERIOD];
   logic [2:0]      next_per;
   logic [2:0]      sel_res;
   logic [31:0]     vc_cur;
   logic            bump;
   logic [CW+2:0]   slot_ext;

   always_comb begin
      slice_ms_sat = (csr_wdata[19:0] < SLICE_MS_MIN) ? SLICE_MS_MIN : csr_wdata[19:0];
      slice_us_in  = SLICE_US_W'(slice_ms_sat) * SLICE_US_W'(US_PER_MS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_us_ff     <= SLICE_US_RESET;
         slot_count_ff   <= '0;
         armed_mask_ff   <= '0;
         period_table_ff <= PERIOD_TABLE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SLICE_MS:     slice_us_ff     <= slice_us_in;
            REG_SLOT_COUNT:   slot_count_ff   <= csr_wdata[3:0];
            REG_ARMED_MASK:   armed_mask_ff   <= csr_wdata[7:0];
            REG_PERIOD_TABLE: period_table_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // ring size and per-slot attributes; slots beyond the masks are unarmed, period 1
   always_comb begin
      if (32'(slot_count_ff) > 32'(WATCHES)) n = NW'(WATCHES);
      else                                  n = NW'(slot_count_ff);
      mask_ext   = XW'(armed_mask_ff);
      period_ext = (3 * XW)'(period_table_ff);
      for (int i = 0; i < WATCHES; i++) begin
         armed_vec[i] = mask_ext[i];
         use_armed[i] = mask_ext[i] && (i < int'(n));
         per_p[i]     = period_ext[3*i +: 3];
         if (per_p[i] == 3'd0) per_p[i] = 3'd1;
         if (per_p[i] > 3'(MAX_PERIOD)) per_p[i] = 3'(MAX_PERIOD);
      end
      first_idx = '0;
      for (int i = WATCHES - 1; i >= 0; i--) begin
         if (use_armed[i]) first_idx = CW'(i);
      end
   end

   // one cursor step and the due test of the slot it lands on
   always_comb begin
      cur_inc   = NW'(cursor_ff) + 1'b1;
      wrap      = (cur_inc == n);
      step_next = src_mod_ff ? mod_ff[CW-1:0] : (wrap ? '0 : cur_inc[CW-1:0]);
      lap_inc   = src_mod_ff || wrap;
      lap_wrap  = (lap_ff == '1);
      for (int k = 0; k < MAX_PERIOD; k++) begin
         if (!lap_inc)                       res_next[k] = res_ff[k];
         else if (lap_wrap)                  res_next[k] = '0;
         else if (res_ff[k] + 3'd1 == 3'(k + 1)) res_next[k] = '0;
         else                                res_next[k] = res_ff[k] + 3'd1;
      end
      next_per = per_p[step_next];
      sel_res  = '0;
      for (int k = 0; k < MAX_PERIOD; k++) begin
         if (next_per == 3'(k + 1)) sel_res = res_next[k];
      end
   end

   always_comb begin
      status.none_armed = (use_armed == '0);
      status.first      = (ho_ff == '0);
      status.over       = ge_ff && (elapsed_ff >= 64'(slice_us_ff));
      status.hold_req   = hold_req_ff;
      status.hold_avail = (hold_cnt_ff < HOLD_W'(MAX_HOLD));
      status.stale      = (NW'(cursor_ff) >= n);
      status.mod_ge_n   = (mod_ff >= n);
      status.due_next   = armed_vec[step_next] && (sel_res == 3'd0);
      status.steps_last = (SW'(steps_ff + 1'b1) == SW'({n, 1'b0}));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ho_ff       <= '0;
         cursor_ff   <= '0;
         hold_cnt_ff <= '0;
         lap_ff      <= '0;
         src_mod_ff  <= 1'b0;
         for (int k = 0; k < MAX_PERIOD; k++) res_ff[k] <= '0;
      end else begin
         if (cmd.start) begin
            ho_ff     <= now_ff;
            cursor_ff <= first_idx;
         end
         if (cmd.hold) begin
            hold_cnt_ff <= hold_cnt_ff + 1'b1;
            ho_ff       <= now_ff;
         end
         if (cmd.search_init) begin
            hold_cnt_ff <= '0;
            ho_ff       <= now_ff;
         end
         if (cmd.reduce_load) src_mod_ff <= 1'b1;
         if (cmd.step) begin
            cursor_ff  <= step_next;
            src_mod_ff <= 1'b0;
            if (lap_inc) lap_ff <= lap_ff + 1'b1;
            for (int k = 0; k < MAX_PERIOD; k++) res_ff[k] <= res_next[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff      <= req_now_us;
         hold_req_ff <= req_hold_request;
      end
      if (cmd.calc) begin
         elapsed_ff <= now_ff - ho_ff;
         ge_ff      <= (now_ff >= ho_ff);
      end
      if (cmd.search_init) begin
         was_ff   <= cursor_ff;
         steps_ff <= '0;
      end
      if (cmd.step) steps_ff <= steps_ff + 1'b1;
      if (cmd.reduce_load) mod_ff <= cur_inc;
      if (cmd.reduce_sub)  mod_ff <= mod_ff - n;
   end

   // visit counters and result register
   assign vc_cur   = vc_ff[cursor_ff];
   assign bump     = (cmd.emit_kind == EMIT_FIRST) || (cmd.emit_kind == EMIT_MOVE);
   assign slot_ext = (CW + 3)'(cursor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WATCHES; i++) vc_ff[i] <= '0;
      end else if (cmd.emit && bump) begin
         vc_ff[cursor_ff] <= vc_cur + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         case (cmd.emit_kind)
            EMIT_NONE: begin
               rsp_active_valid_ff <= 1'b0;
               rsp_active_slot_ff  <= '0;
               rsp_turn_changed_ff <= 1'b0;
               rsp_visit_count_ff  <= '0;
            end
            EMIT_KEEP: begin
               rsp_active_valid_ff <= 1'b1;
               rsp_active_slot_ff  <= slot_ext[2:0];
               rsp_turn_changed_ff <= 1'b0;
               rsp_visit_count_ff  <= vc_cur;
            end
            EMIT_FIRST: begin
               rsp_active_valid_ff <= 1'b1;
               rsp_active_slot_ff  <= slot_ext[2:0];
               rsp_turn_changed_ff <= 1'b1;
               rsp_visit_count_ff  <= vc_cur + 32'd1;
            end
            default: begin
               rsp_active_valid_ff <= 1'b1;
               rsp_active_slot_ff  <= slot_ext[2:0];
               rsp_turn_changed_ff <= (cursor_ff != was_ff);
               rsp_visit_count_ff  <= vc_cur + 32'd1;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_active_valid = rsp_active_valid_ff;
   assign rsp_active_slot  = rsp_active_slot_ff;
   assign rsp_turn_changed = rsp_turn_changed_ff;
   assign rsp_visit_count  = rsp_visit_count_ff;

`include "time_slice_rotation_scheduler_assert.svh"

   `TSRS_ASSERT_IMP(a_hold_bound, clock, reset, 1'b1, hold_cnt_ff <= HOLD_W'(MAX_HOLD), "hold count above limit")
   `TSRS_ASSERT_IMP(a_step_bound, clock, reset, cmd.step, steps_ff < SW'({n, 1'b0}), "search ran past two sweeps")
   `TSRS_ASSERT_NXT(a_lap_only_on_step, clock, reset, !cmd.step, $stable(lap_ff), "lap count moved outside a step")

endmodule

FILE: design/time_slice_rotation_scheduler.sv
// Flow: capture, then check; with no armed slot or on a first grant straight to output,
// a kept or held turn first compares the elapsed time with the slice, and a rotation
// steps slot by slot (at most 2 x slots in use), re-basing a stale cursor first. The
// result loads once the output is free; one item at a time, next input after it loads.
// Reset (synchronous, active high) restores register defaults and clears the handover
// time, cursor, hold and lap counters and all visit counts.
module time_slice_rotation_scheduler import tsrs_pkg::*; #(
   parameter int WATCHES    = WATCHES_DEF,
   parameter int MAX_PERIOD = MAX_PERIOD_DEF,
   parameter int MAX_HOLD   = MAX_HOLD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [63:0]       req_now_us,
   input  logic              req_hold_request,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_active_valid,
   output logic [2:0]        rsp_active_slot,
   output logic              rsp_turn_changed,
   output logic [31:0]       rsp_visit_count
);

   tsrs_cmd_type    cmd;
   tsrs_status_type status;

   tsrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tsrs_dp #(
      .WATCHES    (WATCHES),
      .MAX_PERIOD (MAX_PERIOD),
      .MAX_HOLD   (MAX_HOLD)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_now_us       (req_now_us),
      .req_hold_request (req_hold_request),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_active_valid (rsp_active_valid),
      .rsp_active_slot  (rsp_active_slot),
      .rsp_turn_changed (rsp_turn_changed),
      .rsp_visit_count  (rsp_visit_count),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

FILE: tb/tb_top.sv
module tb_top import tsrs_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUIET_LIMIT = 4000;

   typedef struct packed {
      logic        active_valid;
      logic [2:0]  active_slot;
      logic        turn_changed;
      logic [31:0] visit_count;
   } turn_grant_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;
   logic              req_valid;
   logic              req_stall;
   logic [63:0]       req_now_us;
   logic              req_hold_request;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_active_valid;
   logic [2:0]        rsp_active_slot;
   logic              rsp_turn_changed;
   logic [31:0]       rsp_visit_count;

   time_slice_rotation_scheduler u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_us       (req_now_us),
      .req_hold_request (req_hold_request),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_active_valid (rsp_active_valid),
      .rsp_active_slot  (rsp_active_slot),
      .rsp_turn_changed (rsp_turn_changed),
      .rsp_visit_count  (rsp_visit_count)
   );

   // scheduler shadow: registers and state
   logic [19:0] sched_slice_ms   = SLICE_MS_MIN;
   logic [3:0]  sched_slot_count = '0;
   logic [7:0]  sched_armed      = '0;
   logic [23:0] sched_periods    = PERIOD_TABLE_RESET;
   logic [63:0] turn_mark_us     = '0;
   int unsigned cursor           = 0;
   int unsigned hold_runs        = 0;
   logic [31:0] lap_total        = '0;
   logic [31:0] visit_tally [WATCHES_DEF] = '{default: '0};

   turn_grant_type pending_grants[$];
   int          mismatch_count = 0;
   int          idle_pct;
   int          stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic turn_grant_type predict_turn(input logic [63:0] now, input logic hold);
      turn_grant_type grant;
      int unsigned ring;
      int unsigned armed_in_use;
      int unsigned start;
      int unsigned next;
      int unsigned period;
      logic [63:0] slice_us;
      bit          found;
      grant = '0;
      ring = (sched_slot_count > WATCHES_DEF) ? WATCHES_DEF : sched_slot_count;
      armed_in_use = 0;
      for (int i = 0; i < ring; i++)
         if (sched_armed[i]) armed_in_use++;
      if (ring == 0 || armed_in_use == 0)
         return grant;

      grant.active_valid = 1'b1;
      if (turn_mark_us == 0) begin
         // not started yet: first armed slot from zero
         turn_mark_us = now;
         cursor = 0;
         while (!sched_armed[cursor])
            cursor = (cursor + 1) % ring;
         visit_tally[cursor]++;
         grant.turn_changed = 1'b1;
      end else begin
         slice_us = 64'(sched_slice_ms) * 64'(US_PER_MS);
         if (now < turn_mark_us || now - turn_mark_us < slice_us) begin
            grant.turn_changed = 1'b0;
         end else if (hold && hold_runs < MAX_HOLD_DEF) begin
            hold_runs++;
            turn_mark_us = now;
         end else begin
            hold_runs = 0;
            start = cursor;
            found = 1'b0;
            // two sweeps at most; a wrap counts one lap
            for (int sweep = 0; sweep < 2 && !found; sweep++) begin
               for (int s = 0; s < ring && !found; s++) begin
                  next = (cursor + 1) % ring;
                  if (next <= cursor)
                     lap_total++;
                  cursor = next;
                  period = sched_periods[3*cursor +: 3];
                  if (period == 0)
                     period = 1;
                  if (period > MAX_PERIOD_DEF)
                     period = MAX_PERIOD_DEF;
                  found = sched_armed[cursor] && (lap_total % period == 0);
               end
            end
            turn_mark_us = now;
            visit_tally[cursor]++;
            grant.turn_changed = (cursor != start);
         end
      end
      grant.active_slot = 3'(cursor);
      grant.visit_count = visit_tally[cursor];
      return grant;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("mismatch on %s: got 0x%0h, expected 0x%0h (t=%0t)", field, got, want, $time);
   endtask

   // drop valid and let the block finish everything in flight
   task automatic wait_quiet(input int settle);
      req_valid <= 1'b0;
      while (pending_grants.size() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IW-1:0] index, input logic [CSR_DW-1:0] data);
      wait_quiet(4);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         REG_SLICE_MS:
            sched_slice_ms = (data[19:0] < SLICE_MS_MIN) ? SLICE_MS_MIN : data[19:0];
         REG_SLOT_COUNT:   sched_slot_count = data[3:0];
         REG_ARMED_MASK:   sched_armed = data[7:0];
         REG_PERIOD_TABLE: sched_periods = data[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [63:0] now, input logic hold);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_now_us       <= now;
      req_hold_request <= hold;
      @(posedge clock);
      while (!(req_valid && !req_stall))
         @(posedge clock);
      pending_grants.push_back(predict_turn(now, hold));
      @(negedge clock);
   endtask

   task automatic test_empty_ring();
      send_tick(64'd5000, 1'b0);
      write_csr(REG_SLOT_COUNT, 24'd4);
      send_tick(64'd6000, 1'b1);
   endtask

   // tick at time zero does not start the clock, so the next one is first too
   task automatic test_first_grant();
      write_csr(REG_ARMED_MASK, 24'hF4);
      send_tick(64'd0, 1'b0);
      send_tick(64'd1000, 1'b0);
   endtask

   task automatic test_slice_and_hold();
      send_tick(64'd500, 1'b1);
      send_tick(64'd1000 + 64'd1999999, 1'b1);
      for (int k = 1; k <= 4; k++)
         send_tick(64'd1000 + 64'(k) * 64'd2000000, 1'b1);
      send_tick(turn_mark_us + 64'd10, 1'b0);
   endtask

   // every period clamps to the max, lap count not a multiple: search comes back home
   task automatic test_no_due_slot();
      write_csr(REG_PERIOD_TABLE, 24'hFFFFFF);
      send_tick(turn_mark_us + 64'd2000000, 1'b0);
   endtask

   task automatic test_full_ring();
      write_csr(REG_PERIOD_TABLE, 24'h000000);
      write_csr(REG_ARMED_MASK, 24'hFF);
      write_csr(REG_SLOT_COUNT, 24'd15);
      write_csr(REG_SLICE_MS, 24'd0);
      for (int k = 0; k < 5; k++)
         send_tick(turn_mark_us + 64'd2000000, 1'($urandom_range(0, 1)) & (k == 4));
   endtask

   // shrink the ring under the cursor: old slot reported until the next advance
   task automatic test_stale_cursor();
      write_csr(REG_SLOT_COUNT, 24'd2);
      write_csr(REG_ARMED_MASK, 24'h01);
      send_tick(turn_mark_us + 64'd1000, 1'b0);
      send_tick(turn_mark_us + 64'd2000000, 1'b0);
   endtask

   task automatic test_slice_limits();
      write_csr(REG_SLICE_MS, 24'hFFFFFF);
      send_tick(turn_mark_us + 64'd2000000, 1'b0);
      send_tick(turn_mark_us + 64'd1048575000, 1'b0);
      write_csr(REG_SLICE_MS, 24'd1999);
      send_tick(turn_mark_us + 64'd1999999, 1'b0);
      send_tick(turn_mark_us + 64'd2000000, 1'b0);
   endtask

   task automatic test_random_rotation(input int sender_idle, input int receiver_stall,
                                       input int items);
      logic [63:0] now;
      int unsigned slice_us;
      int unsigned pick;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      for (int seg = 0; seg < 3; seg++) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0:       write_csr(REG_SLICE_MS, 24'($urandom_range(0, 1999)));
            1:       write_csr(REG_SLICE_MS, 24'(SLICE_MS_MIN));
            2:       write_csr(REG_SLICE_MS, 24'hFFFFFF);
            default: write_csr(REG_SLICE_MS, 24'($urandom_range(2000, 6000)));
         endcase
         write_csr(REG_SLOT_COUNT, ($urandom_range(0, 9) == 0) ?
                   24'($urandom_range(0, 15)) : 24'($urandom_range(2, 8)));
         write_csr(REG_ARMED_MASK, ($urandom_range(0, 9) == 0) ?
                   24'd0 : 24'($urandom_range(1, 255)));
         write_csr(REG_PERIOD_TABLE, 24'($urandom()));
         for (int k = 0; k < items / 3; k++) begin
            slice_us = 32'(sched_slice_ms) * 32'(US_PER_MS);
            pick = $urandom_range(0, 99);
            if (pick < 55)
               now = turn_mark_us + 64'(slice_us) + 64'($urandom_range(0, slice_us / 2));
            else if (pick < 80)
               now = turn_mark_us + 64'($urandom_range(0, slice_us - 1));
            else if (pick < 88)
               now = (turn_mark_us > 64'd1000) ?
                     turn_mark_us - 64'($urandom_range(1, 1000)) : 64'd0;
            else if (pick < 95)
               now = {1'b0, 31'($urandom()), $urandom()};
            else
               now = 64'd0;
            send_tick(now, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_time_extremes();
      idle_pct  = 0;
      stall_pct = 0;
      write_csr(REG_SLOT_COUNT, 24'd8);
      write_csr(REG_ARMED_MASK, 24'hFF);
      write_csr(REG_SLICE_MS, 24'd2000);
      send_tick(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_tick(64'd0, 1'b1);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_now_us       = '0;
      req_hold_request = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_SLICE_MS;
      csr_wdata        = '0;
      idle_pct         = 0;
      stall_pct        = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_ring();
      test_first_grant();
      test_slice_and_hold();
      test_no_due_slot();
      test_full_ring();
      test_stale_cursor();
      test_slice_limits();
      test_random_rotation(0, 0, 96);
      test_random_rotation(50, 0, 96);
      test_random_rotation(0, 50, 96);
      test_random_rotation(16, 16, 96);
      test_time_extremes();

      wait_quiet(40);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_grants
      turn_grant_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected result transfer", 64'(rsp_active_slot), 64'd0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_active_valid !== want.active_valid)
               report_mismatch("active_valid", 64'(rsp_active_valid), 64'(want.active_valid));
            if (rsp_active_slot !== want.active_slot)
               report_mismatch("active_slot", 64'(rsp_active_slot), 64'(want.active_slot));
            if (rsp_turn_changed !== want.turn_changed)
               report_mismatch("turn_changed", 64'(rsp_turn_changed), 64'(want.turn_changed));
            if (rsp_visit_count !== want.visit_count)
               report_mismatch("visit_count", 64'(rsp_visit_count), 64'(want.visit_count));
         end
      end
   end

   // no transfer on either side for too long means the block is hung
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: time_slice_rotation_scheduler.f
+incdir+design
design/tsrs_pkg.sv
design/tsrs_ctrl.sv
design/tsrs_dp.sv
design/time_slice_rotation_scheduler.sv
tb/tb_top.sv
